@@ design/gfr_pkg.sv @@
// shared types and constants for the glyph frame store renderer
// holds the command codes and the 6x8 font rom; no dependencies
package gfr_pkg;

   typedef enum logic [1:0] {
      CMD_FILL  = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_GLYPH = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [7:0] GLYPH_FIRST = 8'h20;
   localparam logic [7:0] GLYPH_LAST  = 8'h7E;
   localparam int GLYPH_COLS = 6;

   // store address width at the largest screen (256 columns x 8 pages)
   localparam int ADDR_W = 11;

   // one store access request from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

   function automatic logic [7:0] font_col(input logic [6:0] g, input logic [2:0] c);
      logic [47:0] row;
      unique case (g)
         7'd0:  row = 48'h000000000000; 7'd1:  row = 48'h00005F000000;
         7'd2:  row = 48'h000700070000; 7'd3:  row = 48'h147F147F1400;
         7'd4:  row = 48'h242A7F2A1200; 7'd5:  row = 48'h231308646200;
         7'd6:  row = 48'h364955225000; 7'd7:  row = 48'h000503000000;
         7'd8:  row = 48'h001C22410000; 7'd9:  row = 48'h0041221C0000;
         7'd10: row = 48'h082A1C2A0800; 7'd11: row = 48'h08083E080800;
         7'd12: row = 48'h005030000000; 7'd13: row = 48'h080808080800;
         7'd14: row = 48'h006060000000; 7'd15: row = 48'h201008040200;
         7'd16: row = 48'h3E5149453E00; 7'd17: row = 48'h00427F400000;
         7'd18: row = 48'h426151494600; 7'd19: row = 48'h2141454B3100;
         7'd20: row = 48'h1814127F1000; 7'd21: row = 48'h274545453900;
         7'd22: row = 48'h3C4A49493000; 7'd23: row = 48'h017109050300;
         7'd24: row = 48'h364949493600; 7'd25: row = 48'h064949291E00;
         7'd26: row = 48'h003636000000; 7'd27: row = 48'h005636000000;
         7'd28: row = 48'h000814224100; 7'd29: row = 48'h141414141400;
         7'd30: row = 48'h412214080000; 7'd31: row = 48'h020151090600;
         7'd32: row = 48'h324979413E00; 7'd33: row = 48'h7E1111117E00;
         7'd34: row = 48'h7F4949493600; 7'd35: row = 48'h3E4141412200;
         7'd36: row = 48'h7F4141221C00; 7'd37: row = 48'h7F4949494100;
         7'd38: row = 48'h7F0909010100; 7'd39: row = 48'h3E4141513200;
         7'd40: row = 48'h7F0808087F00; 7'd41: row = 48'h00417F410000;
         7'd42: row = 48'h2040413F0100; 7'd43: row = 48'h7F0814224100;
         7'd44: row = 48'h7F4040404000; 7'd45: row = 48'h7F0204027F00;
         7'd46: row = 48'h7F0408107F00; 7'd47: row = 48'h3E4141413E00;
         7'd48: row = 48'h7F0909090600; 7'd49: row = 48'h3E4151215E00;
         7'd50: row = 48'h7F0919294600; 7'd51: row = 48'h464949493100;
         7'd52: row = 48'h01017F010100; 7'd53: row = 48'h3F4040403F00;
         7'd54: row = 48'h1F2040201F00; 7'd55: row = 48'h7F2018207F00;
         7'd56: row = 48'h631408146300; 7'd57: row = 48'h030478040300;
         7'd58: row = 48'h615149454300; 7'd59: row = 48'h00007F414100;
         7'd60: row = 48'h020408102000; 7'd61: row = 48'h41417F000000;
         7'd62: row = 48'h040201020400; 7'd63: row = 48'h404040404000;
         7'd64: row = 48'h000102040000; 7'd65: row = 48'h205454547800;
         7'd66: row = 48'h7F4844443800; 7'd67: row = 48'h384444442000;
         7'd68: row = 48'h384444487F00; 7'd69: row = 48'h385454541800;
         7'd70: row = 48'h087E09010200; 7'd71: row = 48'h081454543C00;
         7'd72: row = 48'h7F0804047800; 7'd73: row = 48'h00447D400000;
         7'd74: row = 48'h2040443D0000; 7'd75: row = 48'h007F10284400;
         7'd76: row = 48'h00417F400000; 7'd77: row = 48'h7C0418047800;
         7'd78: row = 48'h7C0804047800; 7'd79: row = 48'h384444443800;
         7'd80: row = 48'h7C1414140800; 7'd81: row = 48'h081414187C00;
         7'd82: row = 48'h7C0804040800; 7'd83: row = 48'h485454542000;
         7'd84: row = 48'h043F44402000; 7'd85: row = 48'h3C4040207C00;
         7'd86: row = 48'h1C2040201C00; 7'd87: row = 48'h3C4030403C00;
         7'd88: row = 48'h442810284400; 7'd89: row = 48'h0C5050503C00;
         7'd90: row = 48'h4464544C4400; 7'd91: row = 48'h000836410000;
         7'd92: row = 48'h00007F000000; 7'd93: row = 48'h004136080000;
         7'd94: row = 48'h080408100800;
         default: row = 48'h000000000000;
      endcase
      unique case (c)
         3'd0: font_col = row[47:40];
         3'd1: font_col = row[39:32];
         3'd2: font_col = row[31:24];
         3'd3: font_col = row[23:16];
         3'd4: font_col = row[15:8];
         3'd5: font_col = row[7:0];
         default: font_col = 8'h00;
      endcase
   endfunction

endpackage

@@ design/gfr_store.sv @@
// frame store memory: one write and one read per cycle, registered read data
// depends on gfr_pkg for the access request struct
module gfr_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                clock,
   input  gfr_pkg::mem_req_type req,
   output logic [7:0]          rdata_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr[AW-1:0]] <= req.wdata;
      end
      if (req.rd_en) begin
         rdata_ff <= mem[req.addr[AW-1:0]];
      end
   end

endmodule

@@ design/glyph_framebuffer_renderer.sv @@
// top level of the glyph frame store renderer: command sequencer
// depends on gfr_pkg and gfr_store
//
// one command is taken while busy is low; its single result strobes on rsp_valid
// and must be taken in that cycle since the receiver cannot stall. reset starts a
// clearing pass that writes zero to every byte (one byte a cycle) with busy high
// through the fill and done states. fill writes one byte a cycle, then goes to
// done and strobes; set pixel runs read, modify and write, done, strobe; read
// byte reads the store and strobes; a glyph walks 6 font columns x 8 bits x
// scale^2 pixels, each pixel a read then a write (off screen pixels still take
// their slot); scale 0 goes straight to done. a new command may be taken in the
// strobe cycle. reads return zero out of range and the other commands return
// zero.
module glyph_framebuffer_renderer #(
   parameter int SCREEN_WIDTH = 128,
   parameter int SCREEN_PAGES = 8,
   parameter int MAX_SCALE    = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_x_pos,
   input  logic [7:0] req_y_pos,
   input  logic       req_color,
   input  logic [7:0] req_char_code,
   input  logic [3:0] req_scale,
   input  logic [2:0] req_read_page,
   input  logic [6:0] req_read_column,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data
);

   localparam int DEPTH = SCREEN_WIDTH * SCREEN_PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam int ROWS  = SCREEN_PAGES * 8;
   localparam int MAW   = gfr_pkg::ADDR_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FILL  = 6'b000010,
      ST_RD    = 6'b000100,   // issue read of the target byte
      ST_WR    = 6'b001000,   // modify and write back
      ST_DONE  = 6'b010000,
      ST_RDOUT = 6'b100000    // read command data return
   } state_type;

   state_type   state_ff, state_in;
   logic [AW:0] fill_ff, fill_in;
   logic        fill_val_ff, fill_val_in;
   logic        glyph_ff, glyph_in;
   logic [7:0]  x_ff, x_in, y_ff, y_in;
   logic        color_ff, color_in;
   logic [6:0]  gidx_ff, gidx_in;
   logic [3:0]  scale_ff, scale_in;
   // glyph walk: font column, bit, dy, dx
   logic [2:0]  ci_ff, ci_in, bj_ff, bj_in;
   logic [3:0]  dy_ff, dy_in, dx_ff, dx_in;
   // pixel under work
   logic [AW-1:0] paddr_ff, paddr_in;
   logic [2:0]  pbit_ff, pbit_in;
   logic        pok_ff, pok_in, pon_ff, pon_in;
   logic        rok_ff, rok_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   gfr_pkg::mem_req_type mreq;
   logic [7:0] rdata;

   gfr_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock(clock), .req(mreq), .rdata_ff(rdata)
   );

   // pixel coordinates of the current glyph step (mod 256)
   logic [7:0] gx, gy, font_bits, px, py;
   logic [3:0] sc_eff;
   logic [6:0] code_idx;
   logic       last_dx, last_dy, last_bj, last_ci;

   always_comb begin
      gx = 8'(x_ff + 8'(ci_ff) * 8'(scale_ff) + 8'(dx_ff));
      gy = 8'(y_ff + 8'(bj_ff) * 8'(scale_ff) + 8'(dy_ff));
      font_bits = gfr_pkg::font_col(gidx_ff, ci_ff);
      px = glyph_ff ? gx : x_ff;
      py = glyph_ff ? gy : y_ff;
      last_dx = (dx_ff == 4'(scale_ff - 4'd1));
      last_dy = (dy_ff == 4'(scale_ff - 4'd1));
      last_bj = (bj_ff == 3'd7);
      last_ci = (ci_ff == 3'(gfr_pkg::GLYPH_COLS - 1));
      sc_eff = (req_scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : req_scale;
      code_idx = (req_char_code < gfr_pkg::GLYPH_FIRST || req_char_code > gfr_pkg::GLYPH_LAST)
                 ? 7'd0 : 7'(req_char_code - gfr_pkg::GLYPH_FIRST);
   end

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; fill_val_in = fill_val_ff;
      glyph_in = glyph_ff; x_in = x_ff; y_in = y_ff; color_in = color_ff;
      gidx_in = gidx_ff; scale_in = scale_ff;
      ci_in = ci_ff; bj_in = bj_ff; dy_in = dy_ff; dx_in = dx_ff;
      paddr_in = paddr_ff; pbit_in = pbit_ff; pok_in = pok_ff; pon_in = pon_ff;
      rok_in = rok_ff;
      rsp_valid_in = 1'b0; rsp_data_in = 8'h00;
      mreq = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in = req_x_pos; y_in = req_y_pos; color_in = req_color;
               ci_in = '0; bj_in = '0; dy_in = '0; dx_in = '0;
               unique case (gfr_pkg::cmd_type'(req_cmd))
                  gfr_pkg::CMD_FILL: begin
                     fill_in = '0; fill_val_in = req_color; state_in = ST_FILL;
                  end
                  gfr_pkg::CMD_PIXEL: begin
                     glyph_in = 1'b0; state_in = ST_RD;
                  end
                  gfr_pkg::CMD_GLYPH: begin
                     glyph_in = 1'b1; gidx_in = code_idx; scale_in = sc_eff;
                     state_in = (req_scale == 4'd0) ? ST_DONE : ST_RD;
                  end
                  gfr_pkg::CMD_READ: begin
                     rok_in = (32'(req_read_page) < SCREEN_PAGES)
                              && (32'(req_read_column) < SCREEN_WIDTH);
                     mreq.rd_en = 1'b1;
                     mreq.addr = MAW'(AW'(req_read_column)
                                      + AW'(req_read_page) * AW'(SCREEN_WIDTH));
                     state_in = ST_RDOUT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            mreq.wr_en = 1'b1;
            mreq.addr  = MAW'(fill_ff[AW-1:0]);
            mreq.wdata = {8{fill_val_ff}};
            fill_in = fill_ff + 1'b1;
            if (fill_ff == (AW+1)'(DEPTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_RD: begin
            pok_in  = (32'(px) < SCREEN_WIDTH) && (32'(py) < ROWS);
            paddr_in = AW'(32'(px) + 32'(py[7:3]) * SCREEN_WIDTH);
            pbit_in = py[2:0];
            pon_in  = glyph_ff ? font_bits[bj_ff] : color_ff;
            mreq.rd_en = 1'b1;
            mreq.addr  = MAW'(AW'(32'(px) + 32'(py[7:3]) * SCREEN_WIDTH));
            state_in = ST_WR;
         end
         ST_WR: begin
            mreq.wr_en = pok_ff;
            mreq.addr  = MAW'(paddr_ff);
            mreq.wdata = pon_ff ? (rdata | (8'h01 << pbit_ff))
                                : (rdata & ~(8'h01 << pbit_ff));
            state_in = ST_RD;
            if (!glyph_ff) begin
               state_in = ST_DONE;
            end else begin
               dx_in = dx_ff + 4'd1;
               if (last_dx) begin
                  dx_in = '0; dy_in = dy_ff + 4'd1;
                  if (last_dy) begin
                     dy_in = '0; bj_in = bj_ff + 3'd1;
                     if (last_bj) begin
                        bj_in = '0; ci_in = ci_ff + 3'd1;
                        if (last_ci) state_in = ST_DONE;
                     end
                  end
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1; state_in = ST_IDLE;
         end
         ST_RDOUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in = rok_ff ? rdata : 8'h00;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // reset runs a zero fill; its done strobe is suppressed below
         state_ff <= ST_FILL;
         fill_ff <= '0;
         fill_val_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         glyph_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         fill_val_ff <= fill_val_in;
         rsp_valid_ff <= rsp_valid_in;
         glyph_ff <= glyph_in;
      end
   end

   // marks a pending command so the reset clear gives no transfer
   logic cmd_ff;
   always_ff @(posedge clock) begin
      if (reset) cmd_ff <= 1'b0;
      else if (state_ff == ST_IDLE && start) cmd_ff <= 1'b1;
      else if (rsp_valid_in) cmd_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; color_ff <= color_in;
      gidx_ff <= gidx_in; scale_ff <= scale_in;
      ci_ff <= ci_in; bj_ff <= bj_in; dy_ff <= dy_in; dx_ff <= dx_in;
      paddr_ff <= paddr_in; pbit_ff <= pbit_in; pok_ff <= pok_in; pon_ff <= pon_in;
      rok_ff <= rok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // cmd_ff clears on the strobe edge; keep a copy aligned to the strobe
   logic cmd_pend_ff;
   always_ff @(posedge clock) begin
      if (reset) cmd_pend_ff <= 1'b0;
      else cmd_pend_ff <= cmd_ff;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff && cmd_pend_ff;
   assign rsp_read_data = rsp_data_ff;

   a_busy_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !busy) else $error("busy in idle");
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_IDLE) else $error("result not at end");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
   a_wr_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> $past(state_ff) == ST_RD) else $error("write without read");
   a_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> busy) else $error("transfer not taken");

endmodule
